@@ hdl/point_in_box_assigner_core_macros.svh @@
// Assertion macros shared by the point-in-box assigner RTL.
`ifndef POINT_IN_BOX_ASSIGNER_CORE_MACROS_SVH
`define POINT_IN_BOX_ASSIGNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pib_pkg.sv @@
// Shared constants and types of the point-in-box assigner.
package pib_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int MAX_ELEMENTS_DEF = 1048576;

    localparam int INDEX_W    = 6;
    localparam int ELEM_W     = 20;
    localparam int KIND_W     = 8;
    localparam int ACTIVE_W   = 7;
    localparam int ELEM_CMP_W = 25;

    localparam int KIND_LIMIT = 30;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_POINTS = 1'b0;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TEST = 1'b1;

    typedef struct packed {
        logic we;
        logic re;
    } pib_mem_ctl_t;

endpackage

@@ hdl/pib_ifs.sv @@
// Input and output channel interfaces of the point-in-box assigner.
interface pib_in_if #(
    parameter int COORD_WIDTH = pib_pkg::COORD_WIDTH_DEF
);
    import pib_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [INDEX_W-1:0]            point_index;
    logic signed [COORD_WIDTH-1:0] low_x;
    logic signed [COORD_WIDTH-1:0] low_y;
    logic signed [COORD_WIDTH-1:0] low_z;
    logic signed [COORD_WIDTH-1:0] high_x;
    logic signed [COORD_WIDTH-1:0] high_y;
    logic signed [COORD_WIDTH-1:0] high_z;
    logic [ELEM_W-1:0]             element_number;
    logic [KIND_W-1:0]             element_kind;

    modport source (
        output valid, action, point_index, low_x, low_y, low_z,
        output high_x, high_y, high_z, element_number, element_kind,
        input  ready
    );

    modport sink (
        input  valid, action, point_index, low_x, low_y, low_z,
        input  high_x, high_y, high_z, element_number, element_kind,
        output ready
    );
endinterface

interface pib_out_if;
    import pib_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] receiver_number;
    logic [ELEM_W-1:0]  owner_element;
    logic               last_of_run;

    modport source (
        output valid, receiver_number, owner_element, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, receiver_number, owner_element, last_of_run,
        output ready
    );
endinterface

@@ hdl/point_in_box_assigner_core.sv @@
// Top level of the point-in-box assigner: scan control, result staging, config port.
//
//   channel   dir  handshake       payload
//   item_in   in   valid/ready     action, point_index, low/high x y z, element
//   item_out  out  valid/ready     receiver_number, owner_element, last_of_run
//   apb       in   psel/penable    active_points at address 0
//
// A load item and a skipped box leave the core idle. A box scan makes one read per
// point, up to the capped active_points, through the single read port of the point
// store, then one compare stage and the flush state. Each result waits in a one-entry
// holding stage until the next hit or the end of the scan decides its last flag; a
// hit stalls the scan while that stage is full and the output register holds a result
// not yet taken. Reset clears control state and the register only.
module point_in_box_assigner_core #(
    parameter int MAX_POINTS   = pib_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH  = pib_pkg::COORD_WIDTH_DEF,
    parameter int MAX_ELEMENTS = pib_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pib_in_if.sink                           item_in,
    pib_out_if.source                        item_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pib_pkg::PADDR_W-1:0]      paddr,
    input  logic [pib_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pib_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import pib_pkg::*;
    `include "point_in_box_assigner_core_macros.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW3 = 3 * COORD_WIDTH;
    localparam int DW = CW3 + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [ACTIVE_W-1:0]   MAXP    = ACTIVE_W'(MAX_POINTS);
    localparam logic [ELEM_CMP_W-1:0] MAXE    = ELEM_CMP_W'(MAX_ELEMENTS);
    localparam logic [KIND_W-1:0]     KIND_MX = KIND_W'(KIND_LIMIT);

    logic [1:0]          state_reg, state_next;
    logic [ACTIVE_W-1:0] idx_reg, idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [CW3-1:0]      box_low_reg, box_low_next;
    logic [CW3-1:0]      box_high_reg, box_high_next;
    logic [ELEM_W-1:0]   elem_reg, elem_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic [ELEM_W-1:0]   out_elem_reg, out_elem_next;
    logic                out_last_reg, out_last_next;
    logic [ACTIVE_W-1:0] active_reg;

    pib_mem_ctl_t        mem_ctl;
    logic [AW-1:0]       mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [DW-1:0]       mem_rdata;

    logic                in_box;
    logic                hit;
    logic                stall;
    logic                out_free;
    logic                accept;
    logic                load_ok;
    logic                box_ok;
    logic [ACTIVE_W-1:0] limit;
    logic                push;
    logic [AW-1:0]       push_idx;
    logic                push_last;
    logic                cfg_write;

    pib_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pib_range_check #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_check (
        .point    (mem_rdata[CW3-1:0]),
        .box_low  (box_low_reg),
        .box_high (box_high_reg),
        .in_box   (in_box)
    );

    assign accept   = item_in.valid && item_in.ready;
    assign out_free = !out_valid_reg || item_out.ready;
    assign hit      = cmp_valid_reg && !mem_rdata[CW3] && in_box;
    assign stall    = hit && pend_valid_reg && !out_free;
    assign limit    = (active_reg > MAXP) ? MAXP : active_reg;
    assign load_ok  = {1'b0, item_in.point_index} < MAXP;
    assign box_ok   = (item_in.element_kind <= KIND_MX) &&
                      ({{(ELEM_CMP_W - ELEM_W){1'b0}}, item_in.element_number} < MAXE);

    assign item_in.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        box_low_next    = box_low_reg;
        box_high_next   = box_high_reg;
        elem_next       = elem_reg;
        mem_ctl         = '0;
        mem_waddr       = cmp_idx_reg;
        mem_wdata       = {1'b1, mem_rdata[CW3-1:0]};
        mem_raddr       = idx_reg[AW-1:0];
        push            = 1'b0;
        push_idx        = pend_idx_reg;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_in.action == ACTION_LOAD)
                    begin
                        if (load_ok)
                        begin
                            mem_ctl.we = 1'b1;
                            mem_waddr  = item_in.point_index[AW-1:0];
                            mem_wdata  = {1'b0, item_in.low_z, item_in.low_y,
                                          item_in.low_x};
                        end
                    end
                    else if (box_ok)
                    begin
                        box_low_next  = {item_in.low_z, item_in.low_y, item_in.low_x};
                        box_high_next = {item_in.high_z, item_in.high_y, item_in.high_x};
                        elem_next     = item_in.element_number;
                        idx_next      = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        mem_ctl.we      = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cmp_idx_reg;
                        push            = pend_valid_reg;
                    end
                    if (idx_reg < limit)
                    begin
                        mem_ctl.re     = 1'b1;
                        idx_next       = idx_reg + 1'b1;
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = idx_reg[AW-1:0];
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                        if (!cmp_valid_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = INDEX_W'(push_idx);
            out_elem_next  = elem_reg;
            out_last_next  = push_last;
        end
        else if (item_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        pend_idx_reg <= pend_idx_next;
        box_low_reg  <= box_low_next;
        box_high_reg <= box_high_next;
        elem_reg     <= elem_next;
        out_idx_reg  <= out_idx_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
    end

    assign item_out.valid           = out_valid_reg;
    assign item_out.receiver_number = out_idx_reg;
    assign item_out.owner_element   = out_elem_reg;
    assign item_out.last_of_run     = out_last_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg_write && (paddr[PADDR_W-1:2] == REG_ACTIVE_POINTS))
        begin
            active_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_ACTIVE_POINTS) ?
                    {{(APB_DATA_W - ACTIVE_W){1'b0}}, active_reg} : '0;

    `PIB_ASSERT_IMPLY(a_idle_empty, clk, rst_n, state_reg == ST_IDLE,
        !cmp_valid_reg && !pend_valid_reg, "Scan pipeline not empty while idle.")
    `PIB_ASSERT_IMPLY(a_scan_bound, clk, rst_n, state_reg == ST_SCAN,
        idx_reg <= limit, "Scan index ran past the active point count.")
    `PIB_ASSERT_NEXT(a_stall_hold, clk, rst_n, stall,
        cmp_valid_reg && (cmp_idx_reg == $past(cmp_idx_reg)),
        "Compare stage lost its point during a stall.")

endmodule

@@ hdl/pib_point_mem.sv @@
// Point store: one write port, one registered read port.
module pib_point_mem #(
    parameter int DEPTH = pib_pkg::MAX_POINTS_DEF,
    parameter int AW    = 6,
    parameter int DW    = 3 * pib_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                  clk,
    input  pib_pkg::pib_mem_ctl_t ctl,
    input  logic [AW-1:0]         waddr,
    input  logic [DW-1:0]         wdata,
    input  logic [AW-1:0]         raddr,
    output logic [DW-1:0]         rdata
);
    import pib_pkg::*;

    logic [DW-1:0] store_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pib_range_check.sv @@
// Inclusive three-axis signed containment test of one point against a box.
module pib_range_check #(
    parameter int COORD_WIDTH = pib_pkg::COORD_WIDTH_DEF
) (
    input  logic [3*COORD_WIDTH-1:0] point,
    input  logic [3*COORD_WIDTH-1:0] box_low,
    input  logic [3*COORD_WIDTH-1:0] box_high,
    output logic                     in_box
);
    import pib_pkg::*;

    logic [2:0] axis_ok;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign axis_ok[a] =
            ($signed(box_low[a*COORD_WIDTH +: COORD_WIDTH]) <=
             $signed(point[a*COORD_WIDTH +: COORD_WIDTH])) &&
            ($signed(point[a*COORD_WIDTH +: COORD_WIDTH]) <=
             $signed(box_high[a*COORD_WIDTH +: COORD_WIDTH]));
    end

    assign in_box = &axis_ok;

endmodule

@@ tb/sv/tb_point_in_box_assigner_core.sv @@
// Self-checking testbench for the point-in-box assigner core with random stimulus and stalls.
`timescale 1ns / 1ps

module tb_point_in_box_assigner_core;
    import pib_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int CW = COORD_WIDTH_DEF;

    localparam logic [CW-1:0] COORD_HI = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] COORD_LO = 32'h8000_0000;
    localparam logic [CW-1:0] ONE      = 32'h0001_0000;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = {REG_ACTIVE_POINTS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = {~REG_ACTIVE_POINTS, 2'b00};

    typedef struct packed {
        logic                   action;
        logic [INDEX_W-1:0]     point_index;
        logic [2:0][CW-1:0]     lo;
        logic [2:0][CW-1:0]     hi;
        logic [ELEM_W-1:0]      element_number;
        logic [KIND_W-1:0]      element_kind;
    } box_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] receiver;
        logic [ELEM_W-1:0]  owner;
        logic               last;
    } assignment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    pib_in_if  in_ch ();
    pib_out_if out_ch ();

    point_in_box_assigner_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_ch),
        .item_out (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bit [2:0][CW-1:0] pt_coord [MAX_POINTS_DEF];
    bit pt_marked [MAX_POINTS_DEF];
    bit pt_loaded [MAX_POINTS_DEF];
    logic [ACTIVE_W-1:0] active_points_val = '0;
    assignment_t pending_assignments[$];

    int mismatches = 0;
    int cycle_count = 0;
    logic src_gaps = 1'b1;
    logic sink_gaps = 1'b1;
    logic hold_on = 1'b0;
    event hold_start;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL point_in_box_assigner_core");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // A box marks every active, unmarked point it contains, in rising index order.
    task automatic predict_assignments(input box_item_t it);
        int limit;
        int hits[$];
        bit contained;
        assignment_t a;
        if (it.action == ACTION_LOAD) begin
            pt_coord[it.point_index] = it.lo;
            pt_marked[it.point_index] = 1'b0;
            pt_loaded[it.point_index] = 1'b1;
            return;
        end
        if (it.element_kind > KIND_LIMIT || it.element_number >= MAX_ELEMENTS_DEF)
            return;
        limit = (active_points_val > MAX_POINTS_DEF) ? MAX_POINTS_DEF : active_points_val;
        for (int i = 0; i < limit; i++) begin
            if (!pt_marked[i]) begin
                contained = 1'b1;
                for (int ax = 0; ax < 3; ax++) begin
                    if ($signed(pt_coord[i][ax]) < $signed(it.lo[ax]) ||
                        $signed(pt_coord[i][ax]) > $signed(it.hi[ax]))
                        contained = 1'b0;
                end
                if (contained) begin
                    pt_marked[i] = 1'b1;
                    hits = {hits, i};
                end
            end
        end
        foreach (hits[k]) begin
            a.receiver = INDEX_W'(hits[k]);
            a.owner = it.element_number;
            a.last = (k == hits.size() - 1);
            pending_assignments = {pending_assignments, a};
        end
    endtask

    always @(posedge clk) begin : check_results
        assignment_t exp_a;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_assignments.size() == 0) begin
                report_mismatch($sformatf("unexpected result receiver %0d element %0d",
                                          out_ch.receiver_number, out_ch.owner_element));
            end else begin
                exp_a = pending_assignments.pop_front();
                if (out_ch.receiver_number !== exp_a.receiver)
                    report_mismatch($sformatf("receiver_number %0d, expected %0d",
                                              out_ch.receiver_number, exp_a.receiver));
                if (out_ch.owner_element !== exp_a.owner)
                    report_mismatch($sformatf("owner_element %0d, expected %0d",
                                              out_ch.owner_element, exp_a.owner));
                if (out_ch.last_of_run !== exp_a.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b for receiver %0d",
                                              out_ch.last_of_run, exp_a.last, exp_a.receiver));
            end
        end
    end

    initial begin : drive_result_ready
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_on) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : count_long_hold
        forever begin
            @(hold_start);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_item(input box_item_t it);
        int gap;
        gap = (src_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.action         <= it.action;
        in_ch.point_index    <= it.point_index;
        in_ch.low_x          <= it.lo[0];
        in_ch.low_y          <= it.lo[1];
        in_ch.low_z          <= it.lo[2];
        in_ch.high_x         <= it.hi[0];
        in_ch.high_y         <= it.hi[1];
        in_ch.high_z         <= it.hi[2];
        in_ch.element_number <= it.element_number;
        in_ch.element_kind   <= it.element_kind;
        in_ch.valid          <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_assignments(it);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_assignments.size() != 0) @(posedge clk);
        repeat (MAX_POINTS_DEF + 8) @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        if (is_write && addr[PADDR_W-1:2] == REG_ACTIVE_POINTS)
            active_points_val = wdata[ACTIVE_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_active_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_ACTIVE, '0, rd);
        if (rd[ACTIVE_W-1:0] !== active_points_val)
            report_mismatch($sformatf("active_points read %0d, expected %0d",
                                      rd[ACTIVE_W-1:0], active_points_val));
    endtask

    task automatic write_active_points(input int value);
        logic [APB_DATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, ADDR_ACTIVE, value, rd);
        check_active_readback();
    endtask

    function automatic logic [CW-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_HI;
        if (v < COORD_MIN)
            return COORD_LO;
        return v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return COORD_HI;
            1: return COORD_LO;
            2: return $urandom();
            default: return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
        endcase
    endfunction

    function automatic box_item_t load_of(input int idx, input logic [CW-1:0] x,
                                          input logic [CW-1:0] y, input logic [CW-1:0] z);
        box_item_t it;
        it.action = ACTION_LOAD;
        it.point_index = INDEX_W'(idx);
        it.lo = {z, y, x};
        it.hi = {$urandom(), $urandom(), $urandom()};
        it.element_number = ELEM_W'($urandom_range(0, 32'hF_FFFF));
        it.element_kind = KIND_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic box_item_t random_load(input int idx);
        return load_of(idx, random_coord(), random_coord(), random_coord());
    endfunction

    function automatic box_item_t box_of(input logic [CW-1:0] lx, input logic [CW-1:0] ly,
                                         input logic [CW-1:0] lz, input logic [CW-1:0] hx,
                                         input logic [CW-1:0] hy, input logic [CW-1:0] hz,
                                         input logic [ELEM_W-1:0] elem,
                                         input logic [KIND_W-1:0] kind);
        box_item_t it;
        it.action = ACTION_TEST;
        it.point_index = INDEX_W'($urandom_range(0, MAX_POINTS_DEF - 1));
        it.lo = {lz, ly, lx};
        it.hi = {hz, hy, hx};
        it.element_number = elem;
        it.element_kind = kind;
        return it;
    endfunction

    function automatic box_item_t full_box();
        return box_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                      ELEM_W'($urandom_range(0, 32'hF_FFFF)),
                      KIND_W'($urandom_range(0, KIND_LIMIT)));
    endfunction

    // Boxes are mostly built around a stored point so that they hit often.
    function automatic box_item_t random_box();
        box_item_t it;
        int mode;
        int base;
        longint c;
        it = full_box();
        if ($urandom_range(0, 7) == 0)
            it.element_kind = KIND_W'($urandom_range(KIND_LIMIT + 1, 255));
        base = $urandom_range(0, MAX_POINTS_DEF - 1);
        mode = $urandom_range(0, 9);
        for (int ax = 0; ax < 3; ax++) begin
            c = $signed(pt_coord[base][ax]);
            case (mode)
                0: ;
                1: begin
                    it.lo[ax] = pt_coord[base][ax];
                    it.hi[ax] = pt_coord[base][ax];
                end
                2: begin
                    it.lo[ax] = $urandom();
                    it.hi[ax] = $urandom();
                end
                3: begin
                    it.lo[ax] = clamp_coord(c + 1);
                    it.hi[ax] = clamp_coord(c - longint'($urandom_range(0, 32'h0001_0000)));
                end
                default: begin
                    it.lo[ax] = clamp_coord(c - longint'($urandom_range(0, 32'h0005_0000)));
                    it.hi[ax] = clamp_coord(c + longint'($urandom_range(0, 32'h0005_0000)));
                end
            endcase
        end
        return it;
    endfunction

    task automatic test_directed_loads();
        send_item(load_of(0, 32'h0, 32'h0, 32'h0));
        send_item(load_of(1, COORD_HI, COORD_HI, COORD_HI));
        send_item(load_of(2, COORD_LO, COORD_LO, COORD_LO));
        send_item(load_of(3, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000));
        send_item(load_of(4, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0));
        send_item(load_of(5, COORD_HI, COORD_LO, 32'h0));
        // No point is active yet, so even the whole space assigns nothing.
        send_item(full_box());
    endtask

    task automatic test_directed_boxes();
        send_item(box_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                         20'h1, KIND_W'(KIND_LIMIT + 1)));
        send_item(box_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                         20'h2, 8'hFF));
        send_item(box_of(ONE, COORD_LO, COORD_LO, -ONE, COORD_HI, COORD_HI, 20'h3, 8'h0));
        send_item(box_of(32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
                         32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000, 20'hF_FFFF,
                         KIND_W'(KIND_LIMIT)));
        send_item(box_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'h1, 32'h1, 32'h1, 20'h0, 8'h0));
        send_item(box_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                         20'hA_5A5A, KIND_W'(KIND_LIMIT)));
        send_item(box_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                         20'h5_A5A5, 8'h1));
        // Reloading a point clears its mark.
        send_item(load_of(3, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000));
        send_item(full_box());
    endtask

    task automatic test_ignored_register();
        logic [APB_DATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, ADDR_UNUSED, '0, rd);
        check_active_readback();
        send_item(load_of(0, 32'h0, 32'h0, 32'h0));
        send_item(full_box());
    endtask

    task automatic test_fill_points();
        for (int i = 0; i < MAX_POINTS_DEF; i++) begin
            if (!pt_loaded[i])
                send_item(random_load(i));
        end
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 40)
                send_item(random_load($urandom_range(0, MAX_POINTS_DEF - 1)));
            else
                send_item(random_box());
        end
    endtask

    // The result side holds off while boxes with many hits keep arriving.
    task automatic test_output_backpressure();
        -> hold_start;
        repeat (2) begin
            repeat (12)
                send_item(random_load($urandom_range(0, MAX_POINTS_DEF - 1)));
            send_item(full_box());
        end
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.action         <= ACTION_LOAD;
        in_ch.point_index    <= '0;
        in_ch.low_x          <= '0;
        in_ch.low_y          <= '0;
        in_ch.low_z          <= '0;
        in_ch.high_x         <= '0;
        in_ch.high_y         <= '0;
        in_ch.high_z         <= '0;
        in_ch.element_number <= '0;
        in_ch.element_kind   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_loads();
        write_active_points(6);
        test_directed_boxes();
        test_ignored_register();
        test_fill_points();
        write_active_points(MAX_POINTS_DEF);
        test_random_traffic(12);
        test_output_backpressure();
        write_active_points(100);
        test_random_traffic(8);
        write_active_points($urandom_range(1, MAX_POINTS_DEF - 1));
        test_random_traffic(8);
        write_active_points(0);
        test_random_traffic(4);
        write_active_points(MAX_POINTS_DEF);
        src_gaps <= 1'b0;
        sink_gaps <= 1'b0;
        test_random_traffic(12);

        drain_results();
        repeat (2 * MAX_POINTS_DEF) @(posedge clk);
        if (mismatches == 0)
            $display("PASS point_in_box_assigner_core");
        else
            $display("FAIL point_in_box_assigner_core");
        $finish;
    end

endmodule

@@ point_in_box_assigner_core.f @@
+incdir+hdl
hdl/pib_pkg.sv
hdl/pib_ifs.sv
hdl/pib_point_mem.sv
hdl/pib_range_check.sv
hdl/point_in_box_assigner_core.sv
tb/sv/tb_point_in_box_assigner_core.sv
